/* hdl/sorted_set_merge_macros.svh */
`ifndef SORTED_SET_MERGE_MACROS_SVH
`define SORTED_SET_MERGE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define SSM_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define SSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ssm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package ssm_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned PADDR_W      = 3;

  localparam logic [0:0] REG_SET_OP = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_RUN         = 2'd2
  } ssm_cmd_e;

  typedef enum logic [1:0] {
    OP_UNION     = 2'd0,
    OP_INTERSECT = 2'd1,
    OP_DIFF      = 2'd2
  } ssm_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_FLUSH
  } ssm_state_e;

  typedef struct packed {
    logic              en;
    logic [DATA_W-1:0] value;
  } ssm_load_t;

endpackage
`default_nettype wire

/* hdl/sorted_set_merge.sv */
// Sorted set merge. Two ascending sets of signed 32-bit values are loaded one element per
// request (tuser 0 appends to the first set, 1 to the second); a load into a full set is
// dropped and remembered. A request with tuser 2 runs the merge selected by the
// set_operation register (0 union, 1 intersection, 2 first minus second) and clears both
// sets. Results leave in ascending order with tlast on the final one; an empty answer gives
// one result with value zero and the empty flag set. Every merge step first does the
// synchronous read of the two set memories and then compares and advances the pointers; the
// compare waits while the output is stalled. No new request is taken until the final result
// of a run has been handed to the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "sorted_set_merge_macros.svh"
module sorted_set_merge import ssm_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Request stream.
  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [DATA_W-1:0]  s_axis_tdata,  // element_value
  input  wire logic [1:0]         s_axis_tuser,  // cmd
  // Result stream.
  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic      [DATA_W-1:0]  m_axis_tdata,  // result_value
  output logic                    m_axis_tlast,  // last_result
  output logic      [1:0]         m_axis_tuser   // empty_result, overflow_seen
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  ssm_state_e        state_q, state_d;
  logic [1:0]        op_q, op_d;
  logic [CW-1:0]     i_q, i_d, j_q, j_d, na_q, na_d, nb_q, nb_d;
  logic              ovf_q, ovf_d, run_ovf_q, run_ovf_d;
  logic              held_valid_q, held_valid_d;
  logic [DATA_W-1:0] held_value_q, held_value_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic              out_last_q, out_empty_q, out_ovf_q;

  logic              in_accept, run_req, cfg_wr;
  ssm_load_t         load_a, load_b;
  logic [DATA_W-1:0] a_data, b_data;
  logic [CW-1:0]     cnt_a, cnt_b;
  logic              full_a, full_b;

  logic              op_ok, both, tail_a, tail_b, work, lt, gt;
  logic              emit, adv_i, adv_j, stall, out_free;
  logic [DATA_W-1:0] emit_value;
  logic              out_load, out_load_last, out_load_empty;
  logic [DATA_W-1:0] out_load_value;

  // Configuration register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_SET_OP);
  assign op_d   = cfg_wr ? pwdata[1:0] : op_q;

  always_comb begin
    prdata = '0;
    if (paddr[PADDR_W-1:2] == REG_SET_OP) begin
      prdata = {30'b0, op_q};
    end
  end

  // Set memories.
  assign in_accept    = s_axis_tvalid && s_axis_tready;
  assign run_req      = in_accept && (s_axis_tuser == CMD_RUN);
  assign load_a.en    = in_accept && (s_axis_tuser == CMD_LOAD_FIRST);
  assign load_a.value = s_axis_tdata;
  assign load_b.en    = in_accept && (s_axis_tuser == CMD_LOAD_SECOND);
  assign load_b.value = s_axis_tdata;

  ssm_set_store #(.CAPACITY(CAPACITY)) u_store_a (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_a),
    .clear_i   (run_req),
    .rd_addr_i (i_q[AW-1:0]),
    .rd_data_o (a_data),
    .count_o   (cnt_a),
    .full_o    (full_a)
  );

  ssm_set_store #(.CAPACITY(CAPACITY)) u_store_b (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load_b),
    .clear_i   (run_req),
    .rd_addr_i (j_q[AW-1:0]),
    .rd_data_o (b_data),
    .count_o   (cnt_b),
    .full_o    (full_b)
  );

  always_comb begin
    ovf_d = ovf_q;
    if (run_req) begin
      ovf_d = 1'b0;
    end else if ((load_a.en && full_a) || (load_b.en && full_b)) begin
      ovf_d = 1'b1;
    end
  end

  // Merge step decode.
  assign op_ok  = (op_q == OP_UNION) || (op_q == OP_INTERSECT) || (op_q == OP_DIFF);
  assign both   = (i_q < na_q) && (j_q < nb_q);
  assign tail_a = (i_q < na_q) && (op_q != OP_INTERSECT);
  assign tail_b = (j_q < nb_q) && (op_q == OP_UNION);
  assign work   = op_ok && (both || tail_a || tail_b);
  assign lt     = $signed(a_data) < $signed(b_data);
  assign gt     = $signed(b_data) < $signed(a_data);

  always_comb begin
    emit       = 1'b1;
    emit_value = a_data;
    adv_i      = 1'b0;
    adv_j      = 1'b0;
    if (both) begin
      if (lt) begin
        emit  = (op_q != OP_INTERSECT);
        adv_i = 1'b1;
      end else if (gt) begin
        emit       = (op_q == OP_UNION);
        emit_value = b_data;
        adv_j      = 1'b1;
      end else begin
        emit  = (op_q != OP_DIFF);
        adv_i = 1'b1;
        adv_j = 1'b1;
      end
    end else if (i_q < na_q) begin
      adv_i = 1'b1;
    end else begin
      emit_value = b_data;
      adv_j      = 1'b1;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;
  assign stall    = emit && held_valid_q && !out_free;

  // Sequencer: next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (run_req) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = work ? ST_CMP : ST_FLUSH;
      end
      ST_CMP: begin
        if (!stall) begin
          state_d = ST_READ;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer: outputs and datapath.
  always_comb begin
    s_axis_tready  = 1'b0;
    i_d            = i_q;
    j_d            = j_q;
    na_d           = na_q;
    nb_d           = nb_q;
    run_ovf_d      = run_ovf_q;
    held_valid_d   = held_valid_q;
    held_value_d   = held_value_q;
    out_load       = 1'b0;
    out_load_value = held_value_q;
    out_load_last  = 1'b0;
    out_load_empty = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (run_req) begin
          i_d          = '0;
          j_d          = '0;
          na_d         = cnt_a;
          nb_d         = cnt_b;
          run_ovf_d    = ovf_q;
          held_valid_d = 1'b0;
        end
      end
      ST_READ: begin
      end
      ST_CMP: begin
        if (!stall) begin
          i_d = i_q + CW'(adv_i);
          j_d = j_q + CW'(adv_j);
          if (emit) begin
            held_valid_d = 1'b1;
            held_value_d = emit_value;
            out_load     = held_valid_q;
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          out_load      = 1'b1;
          out_load_last = 1'b1;
          held_valid_d  = 1'b0;
          if (!held_valid_q) begin
            out_load_value = '0;
            out_load_empty = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      op_q         <= OP_UNION;
      i_q          <= '0;
      j_q          <= '0;
      na_q         <= '0;
      nb_q         <= '0;
      ovf_q        <= 1'b0;
      run_ovf_q    <= 1'b0;
      held_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      i_q          <= i_d;
      j_q          <= j_d;
      na_q         <= na_d;
      nb_q         <= nb_d;
      ovf_q        <= ovf_d;
      run_ovf_q    <= run_ovf_d;
      held_valid_q <= held_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    held_value_q <= held_value_d;
    if (out_load) begin
      out_value_q <= out_load_value;
      out_last_q  <= out_load_last;
      out_empty_q <= out_load_empty;
      out_ovf_q   <= run_ovf_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_ovf_q, out_empty_q};

  `SSM_ASSERT_IMPL(a_out_no_overwrite, out_load, out_free, "Output register overwritten.")
  `SSM_ASSERT_IMPL(a_ptr_in_range, state_q != ST_IDLE, (i_q <= na_q) && (j_q <= nb_q), "Pointer past count.")
  `SSM_ASSERT_IMPL(a_empty_is_last, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast, "Empty result without last.")
  `SSM_ASSERT_NEXT(a_run_clears, run_req, (cnt_a == '0) && (cnt_b == '0) && !ovf_q, "Run did not clear state.")

endmodule
`default_nettype wire

/* hdl/ssm_set_store.sv */
`timescale 1ns / 1ps
`default_nettype none
module ssm_set_store import ssm_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF,
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ssm_load_t         load_i,
  input  wire logic              clear_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [DATA_W-1:0] rd_data_o,
  output logic      [CW-1:0]     count_o,
  output logic                   full_o
);

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [CW-1:0]     count_q, count_d;
  logic              wr_en;

  assign full_o  = (count_q == CW'(CAPACITY));
  assign count_o = count_q;
  assign wr_en   = load_i.en && !full_o;

  always_comb begin
    count_d = count_q;
    if (clear_i) begin
      count_d = '0;
    end else if (wr_en) begin
      count_d = count_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[count_q[AW-1:0]] <= load_i.value;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o <= mem[rd_addr_i];
  end

endmodule
`default_nettype wire

/* tb/sorted_set_merge_test.sv */
`timescale 1ns / 1ps
module sorted_set_merge_test import ssm_pkg::*; ();

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned STALL_LIMIT   = 1000;
  localparam int unsigned RANDOM_ITEMS  = 140;

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
    logic               empty;
    logic               overflow;
  } merge_result_t;

  typedef enum logic {
    ROW_REQUEST,
    ROW_SET_OP
  } row_kind_e;

  typedef struct packed {
    row_kind_e     kind;
    ssm_cmd_e      cmd;
    ssm_op_e       op;
    logic [31:0]   value;
    logic [4:0]    count;
    logic          typed;
    merge_result_t want;
  } stim_row_t;

  typedef int int_q_t[$];

  localparam merge_result_t NO_RESULT = '0;
  localparam merge_result_t EMPTY_RUN = '{value: 32'sh0, last: 1'b1, empty: 1'b1,
                                         overflow: 1'b0};

  // Each request row with a count above one loads count elements, value, value + 1, ...
  localparam stim_row_t DIRECTED_ROWS [25] = '{
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'h0000_0000, 5'd1,  1'b1, EMPTY_RUN},
    '{ROW_SET_OP,  CMD_RUN,         OP_INTERSECT, 32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h8000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'hFFFF_FFFF, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h7FFF_FFFF, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h8000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h0000_0005, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h7FFF_FFFF, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'hA5A5_5A5A, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'hFFFF_FFFF, 5'd1,  1'b1, EMPTY_RUN},
    '{ROW_SET_OP,  CMD_RUN,         OP_DIFF,      32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h0000_0013, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h0000_0010, 5'd17, 1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h0000_0009, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h0000_0009, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'h0000_0000, 5'd1,  1'b1, EMPTY_RUN},
    '{ROW_SET_OP,  CMD_RUN,         OP_UNION,     32'h0000_0000, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h0000_0001, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_FIRST,  OP_UNION,     32'h0000_0003, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h0000_0002, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h0000_0003, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_LOAD_SECOND, OP_UNION,     32'h5555_5555, 5'd1,  1'b0, NO_RESULT},
    '{ROW_REQUEST, CMD_RUN,         OP_UNION,     32'h0000_0000, 5'd1,  1'b0, NO_RESULT}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [DATA_W-1:0]  s_tdata = '0;   // element_value
  logic [1:0]         s_tuser = '0;   // cmd
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [DATA_W-1:0]  m_tdata;        // result_value
  logic               m_tlast;        // last_result
  logic [1:0]         m_tuser;        // empty_result, overflow_seen

  // Shadow copy of the block's state.
  logic signed [31:0] first_elems [CAPACITY_DEF];
  logic signed [31:0] second_elems [CAPACITY_DEF];
  int unsigned        first_len = 0;
  int unsigned        second_len = 0;
  logic               dropped_load = 1'b0;
  ssm_op_e            set_op = OP_UNION;

  merge_result_t pending_merge_results[$];

  int unsigned mismatches = 0;
  int unsigned requests_sent = 0;
  int unsigned runs_sent = 0;
  int unsigned overflow_runs = 0;
  int unsigned results_checked = 0;
  int unsigned op_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_stall = 0;
  bit          steady = 1'b0;

  sorted_set_merge uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tlast  (m_tlast),
    .m_axis_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = int'($urandom_range(99));
    if (r < 60) return 0;
    if (r < 92) return int'($urandom_range(3, 1));
    return int'($urandom_range(30, 8));
  endfunction

  function automatic int pick_size();
    int r;
    r = int'($urandom_range(9));
    if (r == 0) return 0;
    if (r == 1) return int'($urandom_range(19, 16));
    return int'($urandom_range(10, 1));
  endfunction

  function automatic int pick_value(bit narrow);
    int r;
    r = int'($urandom_range(15));
    if (r == 0) return int'(32'h8000_0000);
    if (r == 1) return int'(32'h7FFF_FFFF);
    if (narrow) return int'($urandom_range(40)) - 20;
    return int'($urandom);
  endfunction

  function automatic int_q_t ascending(int_q_t vals);
    int_q_t out;
    vals.sort();
    foreach (vals[k]) begin
      if (out.size() == 0 || out[$] != vals[k]) out.push_back(vals[k]);
    end
    return out;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch in %s: got %h, expected %h at %0t ns", field, got, want, $time);
  endtask

  task automatic predict_merge(input ssm_cmd_e cmd, input logic [31:0] value, input bit typed,
                               input merge_result_t typed_res);
    merge_result_t      run_out[$];
    int unsigned        i;
    int unsigned        j;
    logic signed [31:0] a;
    logic signed [31:0] b;
    i = 0;
    j = 0;
    case (cmd)
      CMD_LOAD_FIRST: begin
        if (first_len < CAPACITY_DEF) first_elems[first_len++] = value;
        else dropped_load = 1'b1;
      end
      CMD_LOAD_SECOND: begin
        if (second_len < CAPACITY_DEF) second_elems[second_len++] = value;
        else dropped_load = 1'b1;
      end
      CMD_RUN: begin
        while (i < first_len && j < second_len) begin
          a = first_elems[i];
          b = second_elems[j];
          if (a < b) begin
            if (set_op != OP_INTERSECT) run_out.push_back('{a, 1'b0, 1'b0, dropped_load});
            i++;
          end else if (b < a) begin
            if (set_op == OP_UNION) run_out.push_back('{b, 1'b0, 1'b0, dropped_load});
            j++;
          end else begin
            if (set_op != OP_DIFF) run_out.push_back('{a, 1'b0, 1'b0, dropped_load});
            i++;
            j++;
          end
        end
        if (set_op != OP_INTERSECT) begin
          while (i < first_len) run_out.push_back('{first_elems[i++], 1'b0, 1'b0, dropped_load});
        end
        if (set_op == OP_UNION) begin
          while (j < second_len) run_out.push_back('{second_elems[j++], 1'b0, 1'b0, dropped_load});
        end
        if (run_out.size() == 0) run_out.push_back('{32'sh0, 1'b0, 1'b1, dropped_load});
        run_out[$].last = 1'b1;
        if (typed) pending_merge_results.push_back(typed_res);
        else foreach (run_out[k]) pending_merge_results.push_back(run_out[k]);
        if (dropped_load) overflow_runs++;
        runs_sent++;
        first_len = 0;
        second_len = 0;
        dropped_load = 1'b0;
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_request(input ssm_cmd_e cmd, input logic [31:0] value, input bit typed,
                              input merge_result_t typed_res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    s_tuser  <= cmd;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_merge(cmd, value, typed, typed_res);
    requests_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_merge_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_set_op(input ssm_op_e op);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SET_OP, 2'b00};
    pwdata  <= 32'(op);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    set_op = op;
    op_writes++;
  endtask

  task automatic random_set();
    int_q_t first_vals;
    int_q_t second_vals;
    int     na;
    int     nb;
    int     i;
    int     j;
    bit     narrow;
    bit     noise;
    steady = ($urandom_range(3) == 0);
    narrow = 1'($urandom_range(1));
    noise  = ($urandom_range(7) == 0);
    na = pick_size();
    nb = pick_size();
    repeat (na) first_vals.push_back(pick_value(narrow));
    repeat (nb) begin
      if (na > 0 && $urandom_range(2) == 0)
        second_vals.push_back(first_vals[$urandom_range(na - 1)]);
      else
        second_vals.push_back(pick_value(narrow));
    end
    // Most sets are strictly ascending; the rest go in unsorted and with repeats.
    if (!noise) begin
      first_vals  = ascending(first_vals);
      second_vals = ascending(second_vals);
    end
    i = 0;
    j = 0;
    while (i < first_vals.size() || j < second_vals.size()) begin
      if (j >= second_vals.size() || (i < first_vals.size() && $urandom_range(1) == 1))
        send_request(CMD_LOAD_FIRST, first_vals[i++], 1'b0, NO_RESULT);
      else
        send_request(CMD_LOAD_SECOND, second_vals[j++], 1'b0, NO_RESULT);
    end
    if ($urandom_range(5) == 0) wait_idle();
    send_request(CMD_RUN, $urandom, 1'b0, NO_RESULT);
  endtask

  task automatic check_result();
    merge_result_t want;
    if (pending_merge_results.size() == 0) begin
      report_mismatch("result with nothing expected", m_tdata, '0);
      return;
    end
    want = pending_merge_results.pop_front();
    if (m_tdata !== want.value) report_mismatch("result_value", m_tdata, want.value);
    if (m_tlast !== want.last) report_mismatch("last_result", 32'(m_tlast), 32'(want.last));
    if (m_tuser[0] !== want.empty)
      report_mismatch("empty_result", 32'(m_tuser[0]), 32'(want.empty));
    if (m_tuser[1] !== want.overflow)
      report_mismatch("overflow_seen", 32'(m_tuser[1]), 32'(want.overflow));
    results_checked++;
  endtask

  always @(posedge clk) begin
    int gap;
    gap = pick_gap();
    if (rst_n && m_tvalid && m_tready) check_result();
    if (ready_stall > 0) begin
      ready_stall--;
      m_tready <= 1'b0;
    end else if (gap > 0) begin
      ready_stall = gap - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("no handshake for %0d cycles, %0d results still expected", idle_cycles,
                 pending_merge_results.size());
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int unsigned directed_requests;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_ROWS[r]) begin
      if (DIRECTED_ROWS[r].kind == ROW_SET_OP) begin
        wait_idle();
        write_set_op(DIRECTED_ROWS[r].op);
      end else begin
        for (int k = 0; k < int'(DIRECTED_ROWS[r].count); k++) begin
          send_request(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].value + 32'(k),
                       DIRECTED_ROWS[r].typed && k == int'(DIRECTED_ROWS[r].count) - 1,
                       DIRECTED_ROWS[r].want);
        end
      end
    end
    directed_requests = requests_sent;

    while (requests_sent < directed_requests + RANDOM_ITEMS) begin
      if ($urandom_range(3) == 0) begin
        wait_idle();
        write_set_op(ssm_op_e'($urandom_range(2)));
      end
      random_set();
    end
    wait_idle();

    $display("Covered %0d requests in %0d merge runs (%0d with dropped loads), %0d op writes.",
             requests_sent, runs_sent, overflow_runs, op_writes);
    $display("Checked %0d results, %0d mismatches found.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ssm_pkg.sv
hdl/ssm_set_store.sv
hdl/sorted_set_merge.sv
tb/sorted_set_merge_test.sv
